FILE: hw/rtl/wildcard_mask_matcher_defines.svh
`ifndef WILDCARD_MASK_MATCHER_DEFINES_SVH
`define WILDCARD_MASK_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define WMM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wildcard_mask_matcher: same-cycle check failed");
`define WMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wildcard_mask_matcher: next-cycle check failed");
`else
`define WMM_ASSERT_SAME(lbl, ante, cons)
`define WMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/wmm_pkg.sv
package wmm_pkg;

  localparam int unsigned MaskLenDef = 32;
  localparam int unsigned SymW       = 21;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned LenW       = 6;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [SymW-1:0] ChAny   = SymW'(32'h3F);
  localparam logic [SymW-1:0] ChStar  = SymW'(32'h2A);
  localparam logic [SymW-1:0] ChUpA   = SymW'(32'h41);
  localparam logic [SymW-1:0] ChUpZ   = SymW'(32'h5A);
  localparam logic [SymW-1:0] FoldOfs = SymW'(32'h20);

  typedef enum logic [CmdW-1:0] {
    CmdLoad = 2'd0,
    CmdName = 2'd1,
    CmdEnd  = 2'd2
  } cmd_e;

  typedef enum logic {
    RegMaskLen  = 1'b0,
    RegFoldCase = 1'b1
  } reg_e;

  typedef struct packed {
    logic wr;
    logic active;
    logic fold;
  } cell_ctl_t;

  function automatic logic [SymW-1:0] fold_sym(input logic [SymW-1:0] c, input logic en);
    if (en && (c >= ChUpA) && (c <= ChUpZ)) begin
      return c + FoldOfs;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/wmm_if.sv
interface wmm_req_if import wmm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [SlotW-1:0] slot;
  logic [SymW-1:0] symbol;

  modport source (output valid, cmd, slot, symbol, input ready);
  modport sink   (input valid, cmd, slot, symbol, output ready);
endinterface

interface wmm_rsp_if ();
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

FILE: hw/rtl/wmm_cell.sv
module wmm_cell import wmm_pkg::*; (
  input  logic            clk_i,
  input  cell_ctl_t       ctl_i,
  input  logic [SymW-1:0] sym_i,
  input  logic [SymW-1:0] name_i,
  input  logic            live_i,
  output logic            star_o,
  output logic            stay_o,
  output logic            fwd_o
);

  logic [SymW-1:0] mask_q;
  logic [SymW-1:0] mask_d;
  logic            is_star;
  logic            hit;

  assign mask_d = ctl_i.wr ? sym_i : mask_q;

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
  end

  assign is_star = (mask_q == ChStar);
  assign hit     = (mask_q == ChAny) || (fold_sym(mask_q, ctl_i.fold) == name_i);
  assign star_o  = ctl_i.active & is_star;
  assign stay_o  = live_i & star_o;
  assign fwd_o   = live_i & ctl_i.active & ~is_star & hit;

endmodule

FILE: hw/rtl/wmm_star_close.sv
module wmm_star_close #(
  parameter int unsigned MASK_LEN = 32
) (
  input  logic [MASK_LEN:0] live_i,
  input  logic [MASK_LEN:0] star_i,
  input  logic [MASK_LEN:0] keep_i,
  output logic [MASK_LEN:0] live_o
);

  // A live star position passes liveness to the next position; a run of
  // stars behaves like a carry chain, so one add resolves the whole run.
  logic [MASK_LEN:0] kept;
  logic [MASK_LEN:0] gen;
  logic [MASK_LEN:0] sum;
  logic [MASK_LEN:0] carry;

  assign kept   = live_i & keep_i;
  assign gen    = star_i & kept;
  assign sum    = star_i + gen;
  assign carry  = sum ^ star_i ^ gen;
  assign live_o = kept | carry;

endmodule

FILE: hw/rtl/wildcard_mask_matcher.sv
// Wildcard mask matcher. Load the mask with one load request per character
// (slot and symbol), set mask_length and fold_case over the APB port, then
// stream name characters and close each name with an end request, which
// returns matched and re-arms the matcher. A load also re-arms it. In the mask
// '*' matches any run, '?' exactly one character; fold_case folds A-Z only.
// Requests may follow back to back: each mask position is a cell of a
// row, all cells update their live bits in the same cycle, and runs of
// stars are resolved by one carry chain across the row. The result of an
// end request sits in an output register, and a new request is taken
// whenever that register is empty or being drained.
`include "wildcard_mask_matcher_defines.svh"

module wildcard_mask_matcher import wmm_pkg::*; #(
  parameter int unsigned MASK_LEN = MaskLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  wmm_req_if.sink             in_i,
  wmm_rsp_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned LvW = $clog2(MASK_LEN + 1);
  localparam logic [MASK_LEN:0] LiveOne = (MASK_LEN + 1)'(1);

  logic [LenW-1:0]   len_q;
  logic              fold_q;
  logic [MASK_LEN:0] live_q;
  logic [MASK_LEN:0] live_d;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              matched_q;

  logic              cfg_wr;
  reg_e              cfg_idx;
  logic              accept;
  cmd_e              cmd;
  logic [SymW-1:0]   name_f;
  logic [LvW-1:0]    ulen;
  logic [MASK_LEN:0] keep;
  logic [MASK_LEN:0] star_v;
  logic [MASK_LEN:0] stay_v;
  logic [MASK_LEN-1:0] fwd;
  logic [MASK_LEN:0] live_c;
  logic [MASK_LEN:0] live_next;
  logic              hit;
  cell_ctl_t         ctl [MASK_LEN];

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      RegMaskLen:  prdata = ApbDataW'(len_q);
      RegFoldCase: prdata = ApbDataW'(fold_q);
      default:     prdata = '0;
    endcase
  end

  assign ulen = (32'(len_q) > MASK_LEN) ? LvW'(MASK_LEN) : LvW'(len_q);

  assign accept     = in_i.valid & in_i.ready;
  assign cmd        = cmd_e'(in_i.cmd);
  assign name_f     = fold_sym(in_i.symbol, fold_q);
  assign in_i.ready = ~out_valid_q | out_o.ready;

  for (genvar g = 0; g <= MASK_LEN; g++) begin : g_keep
    assign keep[g] = (LvW'(g) <= ulen);
  end

  for (genvar g = 0; g < MASK_LEN; g++) begin : g_cell
    assign ctl[g].wr     = accept && (cmd == CmdLoad) && (32'(in_i.slot) == g);
    assign ctl[g].active = (LvW'(g) < ulen);
    assign ctl[g].fold   = fold_q;

    wmm_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[g]),
      .sym_i  (in_i.symbol),
      .name_i (name_f),
      .live_i (live_c[g]),
      .star_o (star_v[g]),
      .stay_o (stay_v[g]),
      .fwd_o  (fwd[g])
    );
  end

  assign star_v[MASK_LEN] = 1'b0;
  assign stay_v[MASK_LEN] = 1'b0;

  wmm_star_close #(
    .MASK_LEN (MASK_LEN)
  ) u_close (
    .live_i (live_q),
    .star_i (star_v),
    .keep_i (keep),
    .live_o (live_c)
  );

  assign live_next = stay_v | {fwd, 1'b0};
  assign hit       = live_c[ulen];

  always_comb begin
    live_d = live_q;
    if (accept) begin
      unique case (cmd)
        CmdLoad: live_d = LiveOne;
        CmdName: live_d = live_next;
        CmdEnd:  live_d = LiveOne;
        default: live_d = live_q;
      endcase
    end
  end

  assign out_valid_d = (accept && (cmd == CmdEnd)) | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      fold_q      <= 1'b0;
      live_q      <= LiveOne;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          RegMaskLen:  len_q  <= pwdata[LenW-1:0];
          RegFoldCase: fold_q <= pwdata[0];
          default: ;
        endcase
      end
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd == CmdEnd)) begin
      matched_q <= hit;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = matched_q;

  `WMM_ASSERT_NEXT(a_end_gives_result, accept && (cmd == CmdEnd), out_o.valid)
  `WMM_ASSERT_NEXT(a_load_rearms, accept && (cmd == CmdLoad), live_q == LiveOne)
  `WMM_ASSERT_NEXT(a_no_spurious_result, accept && (cmd != CmdEnd) && out_o.ready, !out_o.valid)
  `WMM_ASSERT_SAME(a_full_stalls_input, out_o.valid && !out_o.ready, !in_i.ready)

endmodule

FILE: verif/tb_wildcard_mask_matcher.sv
`timescale 1ns / 1ps

module tb_wildcard_mask_matcher;
  import wmm_pkg::*;

  localparam int unsigned Depth = MaskLenDef;
  localparam logic [CmdW-1:0] CmdVoid = 2'd3;
  localparam logic [SymW-1:0] ChLowA = ChUpA + FoldOfs;
  localparam logic [SymW-1:0] SymMax = SymW'(1114111);
  localparam int unsigned LenMax = (1 << LenW) - 1;
  localparam int unsigned ItemTarget = 450;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MinPhases = 4;
  localparam realtime TimeLimit = 4_000_000ns;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [SlotW-1:0] slot;
    logic [SymW-1:0]  symbol;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  wmm_req_if req_bus ();
  wmm_rsp_if rsp_bus ();

  wildcard_mask_matcher DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_bus),
    .out_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  request_t pending_requests[$];
  logic due_matches[$];
  int unsigned mismatch_count = 0;
  int unsigned item_count = 0;
  bit offering = 1'b0;
  bit fired = 1'b0;
  bit idle_on = 1'b1;
  bit hold_ready = 1'b0;
  bit hold_start = 1'b0;

  // Shadow of the matcher: mask contents, live positions and both registers.
  logic [SymW-1:0] mask_image[Depth];
  logic [Depth:0] live_set;
  logic [LenW-1:0] len_reg;
  logic fold_reg;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned active_len();
    return (len_reg > Depth) ? Depth : int'(len_reg);
  endfunction

  function automatic logic [SymW-1:0] fold_letter(input logic [SymW-1:0] c);
    if (fold_reg && c >= ChUpA && c <= ChUpZ) begin
      return c + FoldOfs;
    end
    return c;
  endfunction

  function automatic void rearm_live();
    live_set = '0;
    live_set[0] = 1'b1;
  endfunction

  // A live star also makes the position after it live, since it may match
  // an empty run; positions past the mask end are dropped.
  function automatic void spread_live();
    int unsigned n;
    n = active_len();
    for (int unsigned i = n + 1; i <= Depth; i++) begin
      live_set[i] = 1'b0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (live_set[i] && mask_image[i] == ChStar) begin
        live_set[i + 1] = 1'b1;
      end
    end
  endfunction

  function automatic void consume_char(input logic [SymW-1:0] c);
    logic [Depth:0] nxt;
    int unsigned n;
    n = active_len();
    spread_live();
    nxt = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (live_set[i]) begin
        if (mask_image[i] == ChStar) begin
          nxt[i] = 1'b1;
        end else if (mask_image[i] == ChAny || fold_letter(mask_image[i]) == fold_letter(c)) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    live_set = nxt;
    spread_live();
  endfunction

  function automatic void predict_request(input request_t r);
    case (r.cmd)
      CmdLoad: begin
        mask_image[r.slot] = r.symbol;
        rearm_live();
      end
      CmdName: begin
        consume_char(r.symbol);
      end
      CmdEnd: begin
        spread_live();
        due_matches.insert(due_matches.size(), live_set[active_len()]);
        rearm_live();
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  always @(negedge clk_i) begin
    request_t r;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (fired) begin
        offering = 1'b0;
        fired = 1'b0;
      end
      if (!offering && pending_requests.size() != 0 &&
          !(idle_on && $urandom_range(0, 99) < 11)) begin
        r = pending_requests.pop_front();
        req_bus.cmd <= r.cmd;
        req_bus.slot <= r.slot;
        req_bus.symbol <= r.symbol;
        offering = 1'b1;
      end
      req_bus.valid <= offering;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= !hold_ready && !(idle_on && $urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk_i) begin
    request_t r;
    logic want;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        r.cmd = req_bus.cmd;
        r.slot = req_bus.slot;
        r.symbol = req_bus.symbol;
        predict_request(r);
        fired = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (due_matches.size() == 0) begin
          report_mismatch("result with no end-of-name request pending");
        end else begin
          want = due_matches.pop_front();
          if (rsp_bus.matched !== want) begin
            report_mismatch($sformatf("matched is %b, expected %b", rsp_bus.matched, want));
          end
        end
      end
    end
  end

  // The receiver holds off for a long stretch so that the output register
  // fills and the input stalls while requests keep coming.
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    hold_ready = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_ready = 1'b0;
  end

  initial begin
    #(TimeLimit);
    $display("tb: failure");
    $finish;
  end

  task automatic wait_idle();
    while (pending_requests.size() != 0 || offering || due_matches.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_e idx, input logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegMaskLen) begin
      len_reg = value[LenW-1:0];
    end else begin
      fold_reg = value[0];
    end
  endtask

  task automatic push_request(input logic [CmdW-1:0] cmd, input logic [SlotW-1:0] slot,
                              input logic [SymW-1:0] symbol);
    request_t r;
    r.cmd = cmd;
    r.slot = slot;
    r.symbol = symbol;
    pending_requests.insert(pending_requests.size(), r);
    if (cmd != CmdVoid) begin
      item_count++;
    end
  endtask

  function automatic logic [SymW-1:0] pick_literal();
    case ($urandom_range(0, 9))
      0, 1: return SymW'(ChLowA + $urandom_range(0, 2));
      2: return SymW'(ChUpA + $urandom_range(0, 2));
      3: return $urandom_range(0, 1) ? ChUpZ : ChUpZ + FoldOfs;
      4: begin
        case ($urandom_range(0, 3))
          0: return SymW'(ChUpA - 1);
          1: return SymW'(ChUpZ + 1);
          2: return SymW'(ChLowA - 1);
          default: return SymW'(ChUpZ + FoldOfs + 1);
        endcase
      end
      5: return SymW'($urandom_range(0, SymMax));
      6: return '0;
      default: return SymW'(ChLowA + $urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [SymW-1:0] pick_mask_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return ChStar;
      3, 4: return ChAny;
      default: return pick_literal();
    endcase
  endfunction

  function automatic logic [SymW-1:0] flip_case(input logic [SymW-1:0] c);
    if (c >= ChUpA && c <= ChUpZ) begin
      return c + FoldOfs;
    end else if (c >= ChLowA && c <= ChUpZ + FoldOfs) begin
      return c - FoldOfs;
    end
    return c;
  endfunction

  task automatic push_name(input logic [SymW-1:0] word[$], input bit noisy);
    foreach (word[k]) begin
      if (noisy && $urandom_range(0, 39) == 0) begin
        push_request(CmdVoid, SlotW'($urandom_range(0, Depth - 1)),
                     SymW'($urandom_range(0, SymMax)));
      end else if (noisy && $urandom_range(0, 59) == 0) begin
        push_request(CmdLoad, SlotW'($urandom_range(0, Depth - 1)), pick_mask_char());
      end
      push_request(CmdName, SlotW'($urandom_range(0, Depth - 1)), word[k]);
    end
    push_request(CmdEnd, SlotW'($urandom_range(0, Depth - 1)),
                 SymW'($urandom_range(0, SymMax)));
  endtask

  // Most names are built to fit the mask, some of them then damaged by one
  // dropped, added or changed character; the rest are random.
  task automatic push_names(input logic [SymW-1:0] pattern[$], input int unsigned count);
    repeat (count) begin
      logic [SymW-1:0] word[$];
      word = {};
      if ($urandom_range(0, 99) < 85) begin
        foreach (pattern[k]) begin
          if (pattern[k] == ChStar) begin
            repeat ($urandom_range(0, 3)) word.insert(word.size(), pick_literal());
          end else if (pattern[k] == ChAny) begin
            word.insert(word.size(), pick_literal());
          end else begin
            word.insert(word.size(),
                        $urandom_range(0, 1) ? flip_case(pattern[k]) : pattern[k]);
          end
        end
        if ($urandom_range(0, 99) < 30) begin
          case ($urandom_range(0, 2))
            0: begin
              if (word.size() != 0) begin
                word.delete($urandom_range(0, word.size() - 1));
              end
            end
            1: begin
              word.insert($urandom_range(0, word.size()), pick_literal());
            end
            default: begin
              if (word.size() != 0) begin
                word[$urandom_range(0, word.size() - 1)] = pick_literal();
              end
            end
          endcase
        end
      end else begin
        repeat ($urandom_range(0, 6)) word.insert(word.size(), pick_literal());
      end
      push_name(word, 1'b1);
    end
  endtask

  task automatic run_phase(input int unsigned len, input bit fold, input bit quiet);
    logic [SymW-1:0] pattern[$];
    int unsigned n;
    wait_idle();
    idle_on = !quiet;
    write_register(RegMaskLen, len);
    write_register(RegFoldCase, ApbDataW'(fold));
    n = (len > Depth) ? Depth : len;
    pattern = {};
    repeat (n) pattern.insert(pattern.size(), pick_mask_char());
    foreach (pattern[k]) begin
      push_request(CmdLoad, SlotW'(k), pattern[k]);
    end
    if (n < Depth && $urandom_range(0, 2) == 0) begin
      push_request(CmdLoad, SlotW'($urandom_range(n, Depth - 1)), pick_mask_char());
    end
    push_names(pattern, $urandom_range(3, 8));
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned len;
    req_bus.valid = 1'b0;
    req_bus.cmd = '0;
    req_bus.slot = '0;
    req_bus.symbol = '0;
    rsp_bus.ready = 1'b0;
    foreach (mask_image[k]) begin
      mask_image[k] = '0;
    end
    len_reg = '0;
    fold_reg = 1'b0;
    rearm_live();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty mask: only the empty name matches, and code point zero is a
    // character like any other.
    push_request(CmdEnd, '0, '0);
    push_request(CmdName, '1, '0);
    push_request(CmdEnd, '0, SymMax);
    wait_idle();

    // Mask "a?*B" with case folding.
    write_register(RegMaskLen, 4);
    write_register(RegFoldCase, 1);
    push_request(CmdLoad, SlotW'(0), ChLowA);
    push_request(CmdLoad, SlotW'(1), ChAny);
    push_request(CmdLoad, SlotW'(2), ChStar);
    push_request(CmdLoad, SlotW'(3), SymW'(ChUpA + 1));
    push_request(CmdLoad, '1, SymMax);
    push_name('{ChUpA, SymMax, SymW'(ChLowA + 1)}, 1'b0);
    push_name('{ChLowA}, 1'b0);
    push_name('{ChLowA, ChUpZ, '0, SymW'(ChUpZ + 1), SymW'(ChUpA + 1)}, 1'b0);
    push_name('{ChLowA, ChLowA, SymW'(ChUpA + 1), SymW'(ChLowA + 2)}, 1'b0);
    push_request(CmdVoid, '1, SymMax);
    // A load in the middle of a name restarts it.
    push_request(CmdName, '0, ChLowA);
    push_request(CmdLoad, SlotW'(0), ChLowA);
    push_request(CmdEnd, '0, '0);

    phase_no = 0;
    item_count = 0;
    while (item_count < ItemTarget || phase_no < MinPhases) begin
      case (phase_no % 5)
        0: len = Depth;
        1: len = (phase_no == 1) ? LenMax : $urandom_range(Depth + 1, LenMax);
        2: len = $urandom_range(0, 1);
        default: len = $urandom_range(2, 8);
      endcase
      run_phase(len, 1'($urandom_range(0, 1)), phase_no % 4 == 3);
      if (phase_no == 3) begin
        hold_start = 1'b1;
      end
      phase_no++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/wmm_pkg.sv
hw/rtl/wmm_if.sv
hw/rtl/wmm_cell.sv
hw/rtl/wmm_star_close.sv
hw/rtl/wildcard_mask_matcher.sv
verif/tb_wildcard_mask_matcher.sv
